// File: rtl/mstw_pkg.sv
// Package for the minimum spanning forest weight block: widths and status codes.
`default_nettype none
package mstw_pkg;
    localparam int VertexWidth = 11;
    localparam int WeightWidth = 20;
    localparam int SumWidth    = 40;
    localparam int TakenWidth  = 10;
    localparam int RankWidth   = 4;
    localparam logic [RankWidth-1:0] RankMax = 4'd15;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_VERTEX   = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef logic [SumWidth-1:0] sum_t;
endpackage
`default_nettype wire

// File: rtl/min_spanning_tree_weight_top.sv
// Minimum spanning forest weight: edge store, merge sort and union-find sequencer.
//
// Usage: edges arrive on the s_ channel (valid/ready), one transfer per edge,
// at one edge a cycle while loading. An edge with s_last_edge high closes the
// graph: the block drops s_ready, merge sorts the stored edges (log2(E)
// passes; each edge is read, captured, compared and written through one read
// port and one write port on the edge banks) and runs Kruskal's method, where
// each root search and path compression step is a read of the parent memory
// and a wait for its data. One result transfer on the m_ channel follows; it
// is held in the output register while m_ready is low. After it has gone the
// block clears the forest tables (one entry a cycle) with s_ready low, and
// only then accepts the next graph. The same clearing pass runs once after
// reset. vertex_count is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while idle, which the block itself does not
// enforce. Reset sets it to 1024. Out-of-range endpoints and a full store
// are flagged in m_status (vertex error first) and the offending edge is
// dropped.
`default_nettype none
module min_spanning_tree_weight_top
    import mstw_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_wr_en,
    input  wire [VertexWidth-1:0]  cfg_wr_data,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire [VertexWidth-1:0]  s_first_vertex,
    input  wire [VertexWidth-1:0]  s_second_vertex,
    input  wire [WeightWidth-1:0]  s_edge_weight,
    input  wire                    s_last_edge,
    output logic                   m_valid,
    input  wire                    m_ready,
    output logic [SumWidth-1:0]    m_total_weight,
    output logic [TakenWidth-1:0]  m_tree_edges,
    output logic [1:0]             m_status
);
    localparam int VW  = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int NW  = (VW > VertexWidth) ? VW + 1 : VertexWidth + 1;
    localparam int RW  = WeightWidth + 2 * VW;
    localparam int LW  = EW + 2;

    localparam logic [3:0] ST_CLEAR = 4'd0,  ST_LOAD  = 4'd1,  ST_MRD   = 4'd2,
                           ST_MRW   = 4'd3,  ST_MCMP  = 4'd4,  ST_MPASS = 4'd5,
                           ST_KRD   = 4'd6,  ST_KWAIT = 4'd7,  ST_FIND  = 4'd8,
                           ST_FWAIT = 4'd9,  ST_COMP  = 4'd10, ST_CWAIT = 4'd11,
                           ST_JOIN  = 4'd12, ST_JWAIT = 4'd13, ST_OUT   = 4'd14;

    typedef logic [RW-1:0] rec_t;

    // Edge banks bank0_mem and bank1_mem: merge passes read one and write the other
    rec_t bank0_mem [MAX_EDGES];
    rec_t bank1_mem [MAX_EDGES];
    logic [VW-1:0]        parent_mem [MAX_VERTICES];
    logic [RankWidth-1:0] rank_mem   [MAX_VERTICES];

    logic [3:0]           state_reg, state_next;
    logic [NW-1:0]        vcount_reg;
    logic [ECW-1:0]       ecount_reg;
    logic [1:0]           err_reg;
    logic [VW:0]          clr_reg;
    sum_t                 sum_reg;
    logic [TakenWidth-1:0] taken_reg;
    logic                 src_reg;
    logic [LW-1:0]        width_reg, i_reg, j_reg, k_reg, mid_reg, hi_reg;
    logic                 rd_side_reg;
    rec_t                 rd_data, reca_reg, recb_reg;
    logic                 havea_reg, haveb_reg;
    logic [EW-1:0]        rd_addr;
    logic                 rd_bank;
    logic [LW-1:0]        kidx_reg;
    logic [VW-1:0]        cur_reg, ra_reg, end_b_reg, root_reg;
    logic                 side_reg;
    logic [VW-1:0]        par_q;
    logic [RankWidth-1:0] rank_q;
    logic [RankWidth-1:0] rka_reg;
    logic [WeightWidth-1:0] kw_reg;

    // Effective vertex count, clamped to 1..MAX_VERTICES
    logic [NW-1:0] nv;
    always_comb begin
        nv = vcount_reg;
        if (nv == '0) nv = NW'(1);
        if (nv > NW'(MAX_VERTICES)) nv = NW'(MAX_VERTICES);
    end

    logic in_xfer, bad_v, full;
    assign in_xfer = s_valid && s_ready;
    assign bad_v = (s_first_vertex == '0) || (NW'(s_first_vertex) > nv) ||
                   (s_second_vertex == '0) || (NW'(s_second_vertex) > nv);
    assign full = (ecount_reg >= ECW'(MAX_EDGES));
    assign s_ready = (state_reg == ST_LOAD);

    logic [LW-1:0] n_ext;
    assign n_ext = LW'(ecount_reg);

    // Edge bank access: one read port and one write port in total
    logic           wr_en, wr_bank;
    logic [EW-1:0]  wr_addr;
    rec_t           wr_data;
    always_ff @(posedge aclk) begin
        if (wr_en && !wr_bank) bank0_mem[wr_addr] <= wr_data;
        if (wr_en &&  wr_bank) bank1_mem[wr_addr] <= wr_data;
        rd_data <= rd_bank ? bank1_mem[rd_addr] : bank0_mem[rd_addr];
    end

    // Forest table access
    logic           p_we, r_we;
    logic [VW-1:0]  p_waddr, p_wdata, p_raddr, r_waddr, r_raddr;
    logic [RankWidth-1:0] r_wdata;
    always_ff @(posedge aclk) begin
        if (p_we) parent_mem[p_waddr] <= p_wdata;
        if (r_we) rank_mem[r_waddr] <= r_wdata;
        par_q  <= parent_mem[p_raddr];
        rank_q <= rank_mem[r_raddr];
    end

    rec_t a_rec, b_rec;
    assign a_rec = reca_reg;
    assign b_rec = recb_reg;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            vcount_reg <= NW'(1024);
            ecount_reg <= '0;
            err_reg    <= '0;
            clr_reg    <= '0;
            sum_reg    <= '0;
            taken_reg  <= '0;
            m_valid    <= 1'b0;
            src_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) vcount_reg <= NW'(cfg_wr_data);
            state_reg <= state_next;
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (state_next == ST_LOAD) clr_reg <= '0;
                end
                ST_LOAD: begin
                    if (in_xfer) begin
                        if (bad_v) err_reg[0] <= 1'b1;
                        else if (full) err_reg[1] <= 1'b1;
                        else ecount_reg <= ecount_reg + 1'b1;
                        width_reg <= LW'(1);
                        src_reg <= 1'b0;
                    end
                end
                ST_OUT: begin
                    if (!m_valid) begin
                        m_valid <= 1'b1;
                        m_total_weight <= sum_reg;
                        m_tree_edges <= taken_reg;
                        m_status <= err_reg[0] ? STATUS_VERTEX :
                                    (err_reg[1] ? STATUS_OVERFLOW : STATUS_OK);
                    end else if (m_ready) begin
                        m_valid <= 1'b0;
                        ecount_reg <= '0;
                        err_reg <= '0;
                        sum_reg <= '0;
                        taken_reg <= '0;
                    end
                end
                ST_JOIN: begin
                    sum_reg <= sum_reg + sum_t'(kw_reg);
                    taken_reg <= taken_reg + 1'b1;
                end
                ST_MPASS: begin
                    if (state_next == ST_KRD || state_next == ST_MRD) begin
                        if (hi_reg >= n_ext) begin
                            width_reg <= width_reg << 1;
                            src_reg <= ~src_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers without reset
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_LOAD, ST_MPASS: begin
                havea_reg <= 1'b0; haveb_reg <= 1'b0;
                kidx_reg <= '0;
                if (state_reg == ST_LOAD) begin
                    // first pass starts on the pair at 0 and 1
                    i_reg <= '0; j_reg <= LW'(1); k_reg <= '0;
                    mid_reg <= LW'(1); hi_reg <= LW'(2);
                end else if (hi_reg >= n_ext) begin
                    i_reg <= '0; j_reg <= (width_reg << 1); k_reg <= '0;
                    mid_reg <= ((width_reg << 1) < n_ext) ? (width_reg << 1) : n_ext;
                    hi_reg <= ((width_reg << 2) < n_ext) ? (width_reg << 2) : n_ext;
                end else begin
                    i_reg <= hi_reg; j_reg <= hi_reg + width_reg; k_reg <= hi_reg;
                    mid_reg <= (hi_reg + width_reg < n_ext) ? hi_reg + width_reg : n_ext;
                    hi_reg <= (hi_reg + (width_reg << 1) < n_ext) ?
                              hi_reg + (width_reg << 1) : n_ext;
                end
            end
            ST_MRD: rd_side_reg <= (!havea_reg && i_reg < mid_reg) ? 1'b0 : 1'b1;
            ST_MRW: begin
                if (rd_side_reg) begin recb_reg <= rd_data; haveb_reg <= 1'b1; end
                else begin reca_reg <= rd_data; havea_reg <= 1'b1; end
            end
            ST_MCMP: begin
                k_reg <= k_reg + 1'b1;
                if (havea_reg && (!haveb_reg ||
                    !(b_rec[RW-1 -: WeightWidth] < a_rec[RW-1 -: WeightWidth]))) begin
                    havea_reg <= 1'b0; i_reg <= i_reg + 1'b1;
                end else begin
                    haveb_reg <= 1'b0; j_reg <= j_reg + 1'b1;
                end
            end
            ST_KWAIT: begin
                kw_reg <= rd_data[RW-1 -: WeightWidth];
                cur_reg <= rd_data[2*VW-1:VW];
                root_reg <= rd_data[2*VW-1:VW];
                end_b_reg <= rd_data[VW-1:0];
                side_reg <= 1'b0;
            end
            ST_FWAIT: if (par_q != root_reg) root_reg <= par_q;
            ST_CWAIT: begin
                if (par_q == root_reg || cur_reg == root_reg) begin
                    if (!side_reg) begin
                        ra_reg <= root_reg; rka_reg <= rank_q;
                        side_reg <= 1'b1;
                        cur_reg <= end_b_reg; root_reg <= end_b_reg;
                    end
                end else cur_reg <= par_q;
            end
            ST_JWAIT: kidx_reg <= kidx_reg + 1'b1;
            default: ;
        endcase
    end

    // Root search reads parent of root_reg; compression walks cur_reg
    logic comp_done, merge_step_done, want_a;
    assign comp_done = (par_q == root_reg) || (cur_reg == root_reg);
    assign want_a = !havea_reg && (i_reg < mid_reg);
    assign merge_step_done = (k_reg >= hi_reg);

    always_comb begin
        state_next = state_reg;
        wr_en = 1'b0; wr_bank = 1'b0; wr_addr = '0; wr_data = '0;
        rd_bank = src_reg; rd_addr = '0;
        p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = root_reg;
        r_we = 1'b0; r_waddr = '0; r_wdata = '0; r_raddr = root_reg;
        case (state_reg)
            ST_CLEAR: begin
                p_we = 1'b1; p_waddr = clr_reg[VW-1:0]; p_wdata = clr_reg[VW-1:0];
                r_we = 1'b1; r_waddr = clr_reg[VW-1:0];
                if (clr_reg == (VW+1)'(MAX_VERTICES - 1)) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                wr_en = in_xfer && !bad_v && !full;
                wr_addr = ecount_reg[EW-1:0];
                wr_data = {s_edge_weight, VW'(s_first_vertex - 1'b1),
                           VW'(s_second_vertex - 1'b1)};
                if (in_xfer && s_last_edge) begin
                    if (LW'(ecount_reg) + LW'(wr_en) > LW'(1)) state_next = ST_MRD;
                    else state_next = ST_KRD;
                end
            end
            ST_MRD: begin
                if (merge_step_done) state_next = ST_MPASS;
                else if (want_a) begin
                    rd_addr = i_reg[EW-1:0]; state_next = ST_MRW;
                end else if (!haveb_reg && j_reg < hi_reg) begin
                    rd_addr = j_reg[EW-1:0]; state_next = ST_MRW;
                end else state_next = ST_MCMP;
            end
            ST_MRW: state_next = ST_MRD;
            ST_MCMP: begin
                wr_en = 1'b1; wr_bank = ~src_reg; wr_addr = k_reg[EW-1:0];
                if (havea_reg && (!haveb_reg ||
                    !(b_rec[RW-1 -: WeightWidth] < a_rec[RW-1 -: WeightWidth])))
                    wr_data = a_rec;
                else wr_data = b_rec;
                state_next = ST_MRD;
            end
            ST_MPASS: begin
                if (hi_reg >= n_ext && (width_reg << 1) >= n_ext) state_next = ST_KRD;
                else state_next = ST_MRD;
            end
            ST_KRD: begin
                rd_addr = kidx_reg[EW-1:0];
                if (kidx_reg >= n_ext) state_next = ST_OUT;
                else state_next = ST_KWAIT;
            end
            ST_KWAIT: state_next = ST_FIND;
            ST_FIND: state_next = ST_FWAIT;
            ST_FWAIT: if (par_q == root_reg) state_next = ST_COMP; else state_next = ST_FIND;
            ST_COMP: begin p_raddr = cur_reg; state_next = ST_CWAIT; end
            ST_CWAIT: begin
                if (!comp_done) begin
                    p_we = 1'b1; p_waddr = cur_reg; p_wdata = root_reg;
                    state_next = ST_COMP;
                end else if (!side_reg) state_next = ST_FIND;
                else if (root_reg == ra_reg) state_next = ST_JWAIT;
                else state_next = ST_JOIN;
            end
            ST_JOIN: begin
                p_we = 1'b1;
                if (rka_reg < rank_q) begin
                    p_waddr = ra_reg; p_wdata = root_reg;
                end else begin
                    p_waddr = root_reg; p_wdata = ra_reg;
                    if (rka_reg == rank_q && rka_reg < RankMax) begin
                        r_we = 1'b1; r_waddr = ra_reg; r_wdata = rka_reg + 1'b1;
                    end
                end
                state_next = ST_JWAIT;
            end
            ST_JWAIT: state_next = ST_KRD;
            ST_OUT: if (m_valid && m_ready) state_next = ST_CLEAR;
            default: state_next = ST_CLEAR;
        endcase
    end

    // Checks
    a_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> !s_ready) else $error("input taken while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_total_weight)))
        else $error("result dropped while stalled");
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        ecount_reg <= ECW'(MAX_EDGES)) else $error("edge count overflow");
endmodule
`default_nettype wire
